FILE: design/seconds_to_bcd_calendar_assert.svh
// Assertion macros for the seconds to BCD calendar converter.
`ifndef SECONDS_TO_BCD_CALENDAR_ASSERT_SVH
`define SECONDS_TO_BCD_CALENDAR_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define S2BC_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define S2BC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

`endif

FILE: design/s2bc_pkg.sv
// Package with types, constants, microcode and BCD helpers of the calendar converter.
`timescale 1ns / 1ps

package s2bc_pkg;

  localparam int TIME_W    = 31;
  localparam int YCODE_W   = 7;
  localparam int NUM_STEPS = 10;
  localparam int PC_W      = $clog2(NUM_STEPS);

  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [TIME_W-1:0] secs_t;

  localparam secs_t SECS_DAY       = TIME_W'(86400);
  localparam secs_t SECS_TEN_DAYS  = TIME_W'(864000);
  localparam secs_t SECS_YEAR      = TIME_W'(365 * 86400);
  localparam secs_t SECS_LEAP_YEAR = TIME_W'(366 * 86400);
  localparam secs_t SECS_MON28     = TIME_W'(28 * 86400);
  localparam secs_t SECS_MON29     = TIME_W'(29 * 86400);
  localparam secs_t SECS_MON30     = TIME_W'(30 * 86400);
  localparam secs_t SECS_MON31     = TIME_W'(31 * 86400);
  localparam secs_t SECS_TEN_HOURS = TIME_W'(36000);
  localparam secs_t SECS_HOUR      = TIME_W'(3600);
  localparam secs_t SECS_TEN_MINS  = TIME_W'(600);
  localparam secs_t SECS_MIN       = TIME_W'(60);
  localparam secs_t SECS_TEN       = TIME_W'(10);

  localparam logic [4:0] MONTH_DEC = 5'h12;

  typedef enum logic [3:0] {
    K_YEAR, K_MONTH, K_DAY10, K_DAY, K_HOUR10, K_HOUR, K_MIN10, K_MIN, K_SEC10, K_NONE
  } ksel_t;

  typedef enum logic [2:0] {
    D_NONE, D_YEAR, D_MON, D_DAY, D_HOUR, D_MIN, D_SEC
  } dst_t;

  typedef enum logic [2:0] {
    WD_NONE, WD_YEAR, WD_MON, WD_THREE, WD_ONE
  } wdsel_t;

  typedef struct packed {
    ksel_t  ksel;
    dst_t   dst;
    logic   tens;
    wdsel_t wd;
    logic   mon_lim;
    logic   last;
  } ucw_t;

  // Each step subtracts its constant while it fits, counting into a digit;
  // when it no longer fits, or the month step reaches December, the sequencer moves to the next step.
  function automatic ucw_t ucode(pc_t pc);
    ucw_t w;
    w = '{ksel: K_NONE, dst: D_NONE, tens: 1'b0, wd: WD_NONE, mon_lim: 1'b0, last: 1'b1};
    case (pc)
      PC_W'(0): w = '{K_YEAR,   D_YEAR, 1'b0, WD_YEAR,  1'b0, 1'b0};
      PC_W'(1): w = '{K_MONTH,  D_MON,  1'b0, WD_MON,   1'b1, 1'b0};
      PC_W'(2): w = '{K_DAY10,  D_DAY,  1'b1, WD_THREE, 1'b0, 1'b0};
      PC_W'(3): w = '{K_DAY,    D_DAY,  1'b0, WD_ONE,   1'b0, 1'b0};
      PC_W'(4): w = '{K_HOUR10, D_HOUR, 1'b1, WD_NONE,  1'b0, 1'b0};
      PC_W'(5): w = '{K_HOUR,   D_HOUR, 1'b0, WD_NONE,  1'b0, 1'b0};
      PC_W'(6): w = '{K_MIN10,  D_MIN,  1'b1, WD_NONE,  1'b0, 1'b0};
      PC_W'(7): w = '{K_MIN,    D_MIN,  1'b0, WD_NONE,  1'b0, 1'b0};
      PC_W'(8): w = '{K_SEC10,  D_SEC,  1'b1, WD_NONE,  1'b0, 1'b0};
      default: w = '{K_NONE,    D_NONE, 1'b0, WD_NONE,  1'b0, 1'b1};
    endcase
    return w;
  endfunction

  localparam pc_t LAST_PC = PC_W'(NUM_STEPS - 1);

  function automatic logic [7:0] bcd_inc(logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] == 4'd9) begin
      r[3:0] = 4'd0;
      r[7:4] = (v[7:4] == 4'd9) ? 4'd0 : v[7:4] + 4'd1;
    end else begin
      r = {v[7:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

  function automatic logic [7:0] bcd_tens_inc(logic [7:0] v);
    return {v[7:4] + 4'd1, v[3:0]};
  endfunction

  function automatic logic [7:0] code_to_bcd(logic [YCODE_W-1:0] v);
    logic [YCODE_W-1:0] m;
    logic [14:0]        s;
    m = (v >= YCODE_W'(100)) ? v - YCODE_W'(100) : v;
    s = {8'd0, m};
    for (int i = 0; i < YCODE_W; i++) begin
      if (s[10:7] >= 4'd5) s[10:7] = s[10:7] + 4'd3;
      if (s[14:11] >= 4'd5) s[14:11] = s[14:11] + 4'd3;
      s = s << 1;
    end
    return s[14:7];
  endfunction

  function automatic logic is_leap(logic [7:0] y);
    if (y[4]) return (y[3:0] inside {4'd2, 4'd6});
    return (y[3:0] inside {4'd0, 4'd4, 4'd8});
  endfunction

  // Days of the month beyond 28, which is also the month length modulo 7.
  function automatic logic [1:0] month_extra(logic [4:0] mon, logic leap);
    logic [1:0] r;
    case (mon) inside
      5'h02: r = leap ? 2'd1 : 2'd0;
      5'h04, 5'h06, 5'h09, 5'h11: r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

FILE: design/s2bc_chan_if.sv
// Handshake channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps

interface s2bc_in_if import s2bc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface s2bc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] second_bcd;
  logic [6:0] minute_bcd;
  logic [5:0] hour_bcd;
  logic [2:0] weekday_code;
  logic [5:0] day_bcd;
  logic [4:0] month_bcd;
  logic [7:0] year_bcd;
  modport source (output valid, output second_bcd, output minute_bcd, output hour_bcd,
                  output weekday_code, output day_bcd, output month_bcd, output year_bcd,
                  input ready);
  modport sink (input valid, input second_bcd, input minute_bcd, input hour_bcd,
                input weekday_code, input day_bcd, input month_bcd, input year_bcd,
                output ready);
endinterface

interface s2bc_cfg_if import s2bc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YCODE_W-1:0] epoch_year_code;
  modport source (output valid, output epoch_year_code, input ready);
  modport sink (input valid, input epoch_year_code, output ready);
endinterface

FILE: design/seconds_to_bcd_calendar.sv
// Top level of the seconds to BCD calendar converter with its microcoded sequencer.
`timescale 1ns / 1ps
`include "seconds_to_bcd_calendar_assert.svh"

// An item on in_ch is a count of seconds since the epoch. The block converts it
// into BCD seconds, minutes, hours, day, month, chip year and a weekday code,
// and offers one result item on out_ch. cfg_ch writes the chip year code of the
// epoch year; it is always ready and must be written only while the block is idle.
// A ten-step program in a constant table drives one 31-bit subtract-and-compare
// unit. Each step subtracts its constant once per cycle while it fits, then moves
// on. A conversion runs through every step, with one subtraction for each of
// the whole years since the epoch (up to 68), the months (up to 11), and at most
// 42 more for the day, hour, minute and ten-second digits. One item is converted
// at a time; in_ch is ready whenever no conversion runs, also while a finished
// result still waits in the output register. If the receiver stalls and a second
// conversion finishes, that conversion waits in its last step until the register
// is free. Reset sets the year code to 2, clears the sequencer and empties the
// output register.
module seconds_to_bcd_calendar import s2bc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  s2bc_in_if.sink     in_ch,
  s2bc_out_if.source  out_ch,
  s2bc_cfg_if.sink    cfg_ch
);

  logic               busy_r, busy_nxt;
  pc_t                pc_r, pc_nxt;
  secs_t              t_r, t_nxt;
  logic [2:0]         wd_r, wd_nxt;
  logic [7:0]         year_r, year_nxt;
  logic [4:0]         mon_r, mon_nxt;
  logic [5:0]         day_r, day_nxt;
  logic [5:0]         hour_r, hour_nxt;
  logic [6:0]         min_r, min_nxt;
  logic [2:0]         sec_tens_r, sec_tens_nxt;
  logic [YCODE_W-1:0] cfg_year_r, cfg_year_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         o_sec_r, o_sec_nxt;
  logic [6:0]         o_min_r, o_min_nxt;
  logic [5:0]         o_hour_r, o_hour_nxt;
  logic [2:0]         o_wd_r, o_wd_nxt;
  logic [5:0]         o_day_r, o_day_nxt;
  logic [4:0]         o_mon_r, o_mon_nxt;
  logic [7:0]         o_year_r, o_year_nxt;

  ucw_t       w;
  logic       leap;
  logic [1:0] mext;
  secs_t      k;
  logic       take;
  logic [1:0] wd_add;
  logic [3:0] wd_sum;
  logic [2:0] wd_step;
  logic       out_load;
  logic       in_acc;

  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && !busy_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.second_bcd   = o_sec_r;
  assign out_ch.minute_bcd   = o_min_r;
  assign out_ch.hour_bcd     = o_hour_r;
  assign out_ch.weekday_code = o_wd_r;
  assign out_ch.day_bcd      = o_day_r;
  assign out_ch.month_bcd    = o_mon_r;
  assign out_ch.year_bcd     = o_year_r;

  assign w    = ucode(pc_r);
  assign leap = is_leap(year_r);
  assign mext = month_extra(mon_r, leap);

  always_comb begin
    case (w.ksel)
      K_YEAR: k = leap ? SECS_LEAP_YEAR : SECS_YEAR;
      K_MONTH: begin
        case (mext)
          2'd0: k = SECS_MON28;
          2'd1: k = SECS_MON29;
          2'd2: k = SECS_MON30;
          default: k = SECS_MON31;
        endcase
      end
      K_DAY10:  k = SECS_TEN_DAYS;
      K_DAY:    k = SECS_DAY;
      K_HOUR10: k = SECS_TEN_HOURS;
      K_HOUR:   k = SECS_HOUR;
      K_MIN10:  k = SECS_TEN_MINS;
      K_MIN:    k = SECS_MIN;
      K_SEC10:  k = SECS_TEN;
      default:  k = '1;
    endcase
  end

  assign take = (t_r >= k) && !(w.mon_lim && (mon_r == MONTH_DEC));

  always_comb begin
    case (w.wd)
      WD_YEAR:  wd_add = leap ? 2'd2 : 2'd1;
      WD_MON:   wd_add = mext;
      WD_THREE: wd_add = 2'd3;
      WD_ONE:   wd_add = 2'd1;
      default:  wd_add = 2'd0;
    endcase
  end

  assign wd_sum  = {1'b0, wd_r} + {2'b00, wd_add};
  assign wd_step = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

  assign out_load = busy_r && w.last && (!out_valid_r || out_ch.ready);

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    t_nxt         = t_r;
    wd_nxt        = wd_r;
    year_nxt      = year_r;
    mon_nxt       = mon_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_tens_nxt  = sec_tens_r;
    cfg_year_nxt  = cfg_year_r;
    out_valid_nxt = out_valid_r;
    o_sec_nxt     = o_sec_r;
    o_min_nxt     = o_min_r;
    o_hour_nxt    = o_hour_r;
    o_wd_nxt      = o_wd_r;
    o_day_nxt     = o_day_r;
    o_mon_nxt     = o_mon_r;
    o_year_nxt    = o_year_r;

    if (cfg_ch.valid) begin
      cfg_year_nxt = cfg_ch.epoch_year_code;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      busy_nxt     = 1'b1;
      pc_nxt       = '0;
      t_nxt        = in_ch.epoch_seconds;
      wd_nxt       = 3'd2;
      year_nxt     = code_to_bcd(cfg_year_r);
      mon_nxt      = 5'h01;
      day_nxt      = 6'h01;
      hour_nxt     = '0;
      min_nxt      = '0;
      sec_tens_nxt = '0;
    end else if (busy_r) begin
      if (w.last) begin
        if (out_load) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          o_sec_nxt     = {sec_tens_r, t_r[3:0]};
          o_min_nxt     = min_r;
          o_hour_nxt    = hour_r;
          o_wd_nxt      = wd_r + 3'd1;
          o_day_nxt     = day_r;
          o_mon_nxt     = mon_r;
          o_year_nxt    = year_r;
        end
      end else if (take) begin
        t_nxt  = t_r - k;
        wd_nxt = wd_step;
        case (w.dst)
          D_YEAR: year_nxt = bcd_inc(year_r);
          D_MON:  mon_nxt  = 5'(bcd_inc({3'b000, mon_r}));
          D_DAY:  day_nxt  = w.tens ? 6'(bcd_tens_inc({2'b00, day_r}))
                                    : 6'(bcd_inc({2'b00, day_r}));
          D_HOUR: hour_nxt = w.tens ? 6'(bcd_tens_inc({2'b00, hour_r}))
                                    : 6'(bcd_inc({2'b00, hour_r}));
          D_MIN:  min_nxt  = w.tens ? 7'(bcd_tens_inc({1'b0, min_r}))
                                    : 7'(bcd_inc({1'b0, min_r}));
          D_SEC:  sec_tens_nxt = sec_tens_r + 3'd1;
          default: ;
        endcase
      end else begin
        pc_nxt = PC_W'(pc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      cfg_year_r  <= YCODE_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      cfg_year_r  <= cfg_year_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r        <= t_nxt;
    wd_r       <= wd_nxt;
    year_r     <= year_nxt;
    mon_r      <= mon_nxt;
    day_r      <= day_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    sec_tens_r <= sec_tens_nxt;
    o_sec_r    <= o_sec_nxt;
    o_min_r    <= o_min_nxt;
    o_hour_r   <= o_hour_nxt;
    o_wd_r     <= o_wd_nxt;
    o_day_r    <= o_day_nxt;
    o_mon_r    <= o_mon_nxt;
    o_year_r   <= o_year_nxt;
  end

  `S2BC_ASSERT_NEXT(a_accept_starts, in_acc, busy_r && (pc_r == '0))
  `S2BC_ASSERT_NOW(a_pc_in_program, busy_r, pc_r <= LAST_PC)
  `S2BC_ASSERT_NOW(a_month_range, busy_r && (pc_r != '0), (mon_r != 5'h00) && (mon_r <= MONTH_DEC))
  `S2BC_ASSERT_NEXT(a_result_loaded, out_load, out_valid_r && !busy_r)

endmodule
